// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int ID_BITS       = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int TASK_W        = 16;
  localparam int PRIO_IN_W     = 8;
  localparam int OCC_W         = 5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [ID_BITS-1:0]       id;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   fresh;
  } cell_ctrl_t;

endpackage

// ===== design/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Stable min-priority queue of task identifiers in a sorted chain of cells.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tuser carries the mode (0 enqueue, 1 dequeue front),
// s_tdata carries the task identifier and its priority. Lower priority values
// leave first; equal priorities leave in arrival order.
// Output channel m_*: one result per input transfer. m_tuser carries the
// status (0 ok, 1 dequeue on empty, 2 enqueue dropped because full), m_tdata
// the removed identifier (zero unless a dequeue succeeded), the empty flag
// and the occupancy after the operation.
// Every cell compares its priority with the incoming one in parallel, so an
// insert or a pop completes in the cycle of the transfer: m_tvalid is registered
// and rises in the cycle after, and one item is taken per cycle while m_tready holds.
// Reset clears the entry count and m_tvalid; the chain contents and the output
// data are left as they are and only cells below the count are ever read.
// When the receiver stalls, the result holds in the output register and
// s_tready drops until it is taken; s_tready stays high while a result is
// taken in the same cycle.
// ----------------------------------------------------------------------------
module stable_priority_queue
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] task_id, [23:16] priority_req
  input  logic [0:0]  s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] out_task_id, [16] is_empty,
                                 // [21:17] occupancy, [23:22] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  cell_ctrl_t        ctrl;
  status_t           status_next;
  logic [TASK_W-1:0] out_id_next;

  entry_t            entries [CAPACITY];
  logic              les     [CAPACITY];

  logic [TASK_W-1:0] out_task_id;
  status_t           status;
  logic              is_empty;
  logic [OCC_W-1:0]  occupancy;

  logic              take;
  logic              mode;

  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;
  assign mode     = s_tuser[0];

  always_comb begin
    ctrl.op       = OP_HOLD;
    ctrl.fresh.id   = ID_BITS'(s_tdata[TASK_W-1:0]);
    ctrl.fresh.prio = PRIORITY_BITS'(s_tdata[TASK_W +: PRIO_IN_W]);
    count_next    = count;
    status_next   = ST_OK;
    out_id_next   = '0;
    if (take) begin
      if (mode == MODE_ENQ) begin
        if (count == CNT_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          ctrl.op    = OP_INSERT;
          count_next = count + CNT_W'(1);
        end
      end else begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.op     = OP_POP;
          out_id_next = TASK_W'(entries[0].id);
          count_next  = count - CNT_W'(1);
        end
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occupied;
    logic   prev_le;
    entry_t prev_entry;
    entry_t next_entry;

    assign occupied = CNT_W'(i) < count;

    if (i == 0) begin : g_head
      assign prev_le    = 1'b1;
      assign prev_entry = ctrl.fresh;
    end else begin : g_body
      assign prev_le    = les[i-1];
      assign prev_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = entries[i];
    end else begin : g_mid
      assign next_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupied),
      .prev_le    (prev_le),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .entry      (entries[i]),
      .le         (les[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (take) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_task_id <= out_id_next;
      status      <= status_next;
      is_empty    <= (count_next == '0);
      occupancy   <= OCC_W'(count_next);
    end
  end

  assign m_tdata = {2'b00, occupancy, is_empty, out_task_id};
  assign m_tuser = status;

endmodule

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds, shifts back on insert, forward on pop.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       prev_le,
  input  entry_t     prev_entry,
  input  entry_t     next_entry,
  output entry_t     entry,
  output logic       le
);

  entry_t entry_next;

  assign le = occupied && (entry.prio <= ctrl.fresh.prio);

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      OP_INSERT: begin
        if (le) begin
          entry_next = entry;
        end else if (prev_le) begin
          entry_next = ctrl.fresh;
        end else begin
          entry_next = prev_entry;
        end
      end
      OP_POP:  entry_next = next_entry;
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== verif/stable_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb
// Self-checking testbench for the stable priority queue. A driver feeds
// enqueue and dequeue transfers from a pending list with random gaps, and a
// receiver applies random and long stalls. A sorted shadow queue predicts
// each result, and a monitor compares every output transfer field by field.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int ITEM_TARGET = 950;
  localparam int PRESSURE_AT = 400;
  localparam int LONG_HOLD   = 80;
  localparam int DRAIN_WAIT  = 10;
  localparam int PRINT_CAP   = 60;

  typedef struct {
    mode_t                    mode;
    logic [ID_BITS-1:0]       id;
    logic [PRIORITY_BITS-1:0] prio;
  } queue_op_t;

  typedef struct {
    logic [TASK_W-1:0] id;
    status_t           status;
    logic              empty;
    logic [OCC_W-1:0]  occ;
  } queue_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // [15:0] task_id, [23:16] priority_req
  logic [0:0]  s_tuser  = '0;   // [0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [15:0] out_task_id, [16] is_empty,
                                // [21:17] occupancy, [23:22] zero
  logic [1:0]  m_tuser;         // [1:0] status

  queue_op_t     pending_ops[$];
  entry_t        sorted_entries[$];
  queue_result_t expected_results[$];

  int  errors        = 0;
  int  n_accepted    = 0;
  bit  in_took       = 0;
  bit  out_took      = 0;
  int  send_gap      = 0;
  int  rx_wait       = 0;
  int  hold_left     = 0;
  bit  pressure_done = 0;
  wire idle_en       = ((n_accepted / 64) % 3) != 2;

  stable_priority_queue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  function automatic void queue_model_step(mode_t m, logic [ID_BITS-1:0] id,
                                           logic [PRIORITY_BITS-1:0] p);
    queue_result_t r;
    entry_t        e;
    int            pos;
    r.id     = '0;
    r.status = ST_OK;
    if (m == MODE_ENQ) begin
      if (sorted_entries.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_entries.size() && sorted_entries[pos].prio <= p) pos++;
        e.id   = id;
        e.prio = p;
        sorted_entries.insert(pos, e);
      end
    end else if (sorted_entries.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      e    = sorted_entries.pop_front();
      r.id = e.id;
    end
    r.empty = (sorted_entries.size() == 0);
    r.occ   = OCC_W'(sorted_entries.size());
    expected_results.push_back(r);
  endfunction

  task automatic add_op(mode_t m, logic [ID_BITS-1:0] id, logic [PRIORITY_BITS-1:0] p);
    queue_op_t op;
    op.mode = m;
    op.id   = id;
    op.prio = p;
    pending_ops.push_back(op);
  endtask

  function automatic logic [PRIORITY_BITS-1:0] pick_prio(bit ties);
    int r;
    r = $urandom_range(0, 9);
    if (ties) return PRIORITY_BITS'($urandom_range(0, 2));
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return PRIORITY_BITS'($urandom_range(0, 3));
    return PRIORITY_BITS'($urandom);
  endfunction

  // driver: hold until transfer, then wait the drawn gap and present the next
  always @(negedge clk) begin : drive_in
    bit        busy;
    queue_op_t op;
    if (!rst) begin
      busy = s_tvalid && !in_took;
      if (in_took) begin
        in_took  = 0;
        send_gap = idle_en ? $urandom_range(0, 8) : 0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {op.prio, op.id};
          s_tuser  <= op.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall per result, one long hold-off to back up the queue
  always @(negedge clk) begin : drive_out
    if (!rst) begin
      if (!pressure_done && n_accepted >= PRESSURE_AT) begin
        pressure_done = 1;
        hold_left     = LONG_HOLD;
      end
      if (out_took) begin
        out_took = 0;
        rx_wait  = idle_en ? $urandom_range(0, 8) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch
    queue_result_t r;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        queue_model_step(mode_t'(s_tuser[0]), s_tdata[15:0], s_tdata[23:16]);
        in_took = 1;
        n_accepted++;
      end
      if (m_tvalid && m_tready) begin
        out_took = 1;
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          r = expected_results.pop_front();
          if (m_tdata[15:0] !== r.id)
            report_mismatch($sformatf("out_task_id %h, want %h", m_tdata[15:0], r.id));
          if (m_tuser !== r.status)
            report_mismatch($sformatf("status %0d, want %0d", m_tuser, r.status));
          if (m_tdata[16] !== r.empty)
            report_mismatch($sformatf("is_empty %b, want %b", m_tdata[16], r.empty));
          if (m_tdata[21:17] !== r.occ)
            report_mismatch($sformatf("occupancy %0d, want %0d", m_tdata[21:17], r.occ));
          if (m_tdata[23:22] !== 2'b00)
            report_mismatch($sformatf("pad bits %b, want 00", m_tdata[23:22]));
        end
      end
    end
  end

  initial begin
    int kind;
    int len;
    int k;
    bit enq;

    add_op(MODE_DEQ, 16'hFFFF, 8'hFF);
    add_op(MODE_ENQ, 16'hFFFF, 8'hFF);
    add_op(MODE_ENQ, 16'h0000, 8'h00);
    add_op(MODE_ENQ, 16'h0A01, 8'h80);
    add_op(MODE_ENQ, 16'h0A02, 8'h80);
    add_op(MODE_ENQ, 16'h0A03, 8'h80);
    add_op(MODE_DEQ, 16'h0000, 8'h00);
    add_op(MODE_DEQ, 16'h5A5A, 8'hA5);
    for (k = 0; k < 14; k++) begin
      add_op(MODE_ENQ, 16'hC000 + 16'(k), 8'(k * 19));
    end

    while (pending_ops.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(4, 20);
      for (k = 0; k < len; k++) begin
        case (kind)
          0, 1, 2: enq = 1;
          3, 4:    enq = 0;
          5, 6, 7: enq = ($urandom_range(0, 9) < 6);
          default: enq = $urandom_range(0, 1);
        endcase
        add_op(enq ? MODE_ENQ : MODE_DEQ, ID_BITS'($urandom), pick_prio(kind >= 8));
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("stable_priority_queue_tb: clean");
    end else begin
      $display("stable_priority_queue_tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("stable_priority_queue_tb: errors");
    $finish;
  end

endmodule
